// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers; empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ----- hw/rtl/bspf_pkg.sv -----
`default_nettype none
package bspf_pkg;

	localparam int COORD_BITS     = 24;
	localparam int EXT_BITS       = 23;
	localparam int IDX_BITS       = 16;
	localparam int MAX_PRIMITIVES = 32;
	localparam int CFG_IDX_BITS   = 2;

	localparam int DIFF_BITS = COORD_BITS + 1;
	localparam int SUM_BITS  = EXT_BITS + 2;
	localparam int MAG_BITS  = (DIFF_BITS > SUM_BITS) ? DIFF_BITS : SUM_BITS;
	localparam int SQ_BITS   = 2 * MAG_BITS;
	localparam int ACC_BITS  = SQ_BITS + 2;

	localparam logic [1:0] FUNC_SET_A = 2'd0;
	localparam logic [1:0] FUNC_SET_B = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;

	localparam logic [1:0] MODE_ALL    = 2'd0;
	localparam logic [1:0] MODE_CROSS  = 2'd2;

	localparam logic [CFG_IDX_BITS-1:0] REG_PAIR_MODE   = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] REG_NEAR_RADIUS = CFG_IDX_BITS'(1);

	typedef struct packed {
		logic [1:0]                   func;
		logic signed [COORD_BITS-1:0] center_x;
		logic signed [COORD_BITS-1:0] center_y;
		logic signed [COORD_BITS-1:0] center_z;
		logic [EXT_BITS-1:0]          extent;
	} in_item_t;

	typedef struct packed {
		logic [IDX_BITS-1:0] first_index;
		logic [IDX_BITS-1:0] second_index;
		logic                pair_valid;
		logic                overflow;
		logic                last_of_run;
	} result_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic signed [COORD_BITS-1:0] z;
		logic [EXT_BITS-1:0]          extent;
	} prim_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_OVF,
		ST_FIN,
		ST_DRAIN
	} state_t;

	typedef enum logic [1:0] {
		SLOT_CMP,
		SLOT_FIN,
		SLOT_OVF
	} slot_kind_t;

	typedef struct packed {
		logic                valid;
		slot_kind_t          kind;
		logic [IDX_BITS-1:0] idx;
	} slot_t;

endpackage
`default_nettype wire

// ----- hw/rtl/bounding_sphere_pair_finder_core.sv -----
// Broad-phase bounding-sphere pair finder.
// Input channel (in_valid/in_ready/in_data): one primitive or command per
// transfer. in_ready is high only while no item is in flight.
// Output channel (out_valid/out_ready/out_data): pair results, or one
// overflow result, the final result of an item carrying last_of_run.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
// index 0 pair_mode, 1 near_radius; write only while idle.
// Sequencing: after a primitive transfer, the scan reads one store entry
// per cycle while the output does not stall, through the single read port
// of the store memory; then a four-stage distance pipeline drains before
// the next transfer is taken. Overflow items and items with nothing to
// test skip the scan; clear and unused codes are taken without leaving idle.
// Reset: stored and set-a counts go to zero, pair_mode to 1, near_radius
// to 0; store contents are undefined and never read before written.
// Stall: while a result waits in the output register and out_ready is
// low, the scan and pipeline freeze; nothing is lost or repeated.
`default_nettype none
`include "assert_macros.svh"
module bounding_sphere_pair_finder_core #(
	parameter int MAX_PRIMITIVES = bspf_pkg::MAX_PRIMITIVES
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  bspf_pkg::in_item_t                in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output bspf_pkg::result_t                 out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bspf_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [bspf_pkg::EXT_BITS-1:0]     cfg_data
);
	import bspf_pkg::*;

	localparam int AW = $clog2(MAX_PRIMITIVES);
	localparam int CW = $clog2(MAX_PRIMITIVES + 1);

	logic [1:0]          pair_mode_q;
	logic [EXT_BITS-1:0] near_radius_q;
	logic [CW-1:0]       stored_count_q;
	logic [IDX_BITS-1:0] set_a_count_q;
	state_t              state_q, state_d;
	prim_t               item_q;
	logic                all_q, cross_q;
	logic [IDX_BITS-1:0] base_q;
	logic [CW-1:0]       n_cmp_q, k_q;
	result_t             pend_q, out_q;
	logic                pend_valid_q, out_valid_q;

	logic    accept, is_prim, is_cross, store_full, cross_full, do_store, ovf;
	logic    advance, ram_re;
	logic [CW-1:0] n_cmp_d;
	prim_t   in_prim, entry_s1;
	slot_t   slot_in, slot_s1, slot_s4;
	logic    hit_s4, take_hit, take_fin;
	result_t hit_res;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign advance   = !out_valid_q || out_ready;

	assign is_prim    = (in_data.func == FUNC_SET_A) || (in_data.func == FUNC_SET_B);
	assign is_cross   = (pair_mode_q == MODE_CROSS) && (in_data.func == FUNC_SET_A);
	assign store_full = (stored_count_q == CW'(MAX_PRIMITIVES));
	assign cross_full = (set_a_count_q == {IDX_BITS{1'b1}});
	assign ovf        = is_prim && (is_cross ? cross_full : store_full);
	assign do_store   = accept && is_prim && !is_cross && !store_full;
	assign n_cmp_d    = (is_cross || pair_mode_q != MODE_CROSS) ? stored_count_q : '0;

	assign in_prim = '{x: in_data.center_x, y: in_data.center_y,
		z: in_data.center_z, extent: in_data.extent};

	// Configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_mode_q   <= 2'd1;
			near_radius_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PAIR_MODE:   pair_mode_q   <= cfg_data[1:0];
				REG_NEAR_RADIUS: near_radius_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_count_q <= '0;
			set_a_count_q  <= '0;
		end else if (accept) begin
			if (in_data.func == FUNC_CLEAR) begin
				stored_count_q <= '0;
				set_a_count_q  <= '0;
			end else if (do_store) begin
				stored_count_q <= stored_count_q + CW'(1);
			end else if (is_prim && is_cross && !cross_full) begin
				set_a_count_q <= set_a_count_q + IDX_BITS'(1);
			end
		end
	end

	// Item context
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q  <= in_prim;
			all_q   <= (pair_mode_q == MODE_ALL);
			cross_q <= is_cross;
			base_q  <= is_cross ? set_a_count_q : IDX_BITS'(stored_count_q);
			n_cmp_q <= n_cmp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (accept) begin
			k_q <= '0;
		end else if (state_q == ST_SCAN && advance) begin
			k_q <= k_q + CW'(1);
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && is_prim) begin
					if (ovf) begin
						state_d = ST_OVF;
					end else if (n_cmp_d == '0) begin
						state_d = ST_FIN;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (advance && k_q == n_cmp_q - CW'(1)) begin
					state_d = ST_FIN;
				end
			end
			ST_OVF: begin
				if (advance) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (advance) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (take_fin) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		slot_in = '0;
		ram_re  = 1'b0;
		unique case (state_q)
			ST_SCAN: begin
				slot_in = '{valid: 1'b1, kind: SLOT_CMP, idx: IDX_BITS'(k_q)};
				ram_re  = advance;
			end
			ST_OVF:  slot_in = '{valid: 1'b1, kind: SLOT_OVF, idx: '0};
			ST_FIN:  slot_in = '{valid: 1'b1, kind: SLOT_FIN, idx: '0};
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_s1 <= '0;
		end else if (advance) begin
			slot_s1 <= slot_in;
		end
	end

	// Reads happen only while scanning and writes only on a transfer in idle,
	// so the two ports never touch the same entry in one cycle.
	bspf_ram #(
		.WIDTH  ($bits(prim_t)),
		.DEPTH  (MAX_PRIMITIVES),
		.ADDR_W (AW)
	) u_store (
		.clk   (clk),
		.we    (do_store),
		.waddr (stored_count_q[AW-1:0]),
		.wdata (in_prim),
		.re    (ram_re),
		.raddr (k_q[AW-1:0]),
		.rdata (entry_s1)
	);

	bspf_near u_near (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.slot_s1     (slot_s1),
		.entry_s1    (entry_s1),
		.item        (item_q),
		.near_radius (near_radius_q),
		.slot_s4     (slot_s4),
		.hit_s4      (hit_s4)
	);

	// Result staging: one result is held back until the next one or the
	// end of the run shows whether it is the last.
	assign take_hit = advance && slot_s4.valid
		&& ((slot_s4.kind == SLOT_OVF) || (slot_s4.kind == SLOT_CMP && (all_q || hit_s4)));
	assign take_fin = advance && slot_s4.valid && (slot_s4.kind == SLOT_FIN);

	always_comb begin
		hit_res = '0;
		if (slot_s4.kind == SLOT_OVF) begin
			hit_res.overflow = 1'b1;
		end else begin
			hit_res.pair_valid   = 1'b1;
			hit_res.first_index  = cross_q ? base_q : slot_s4.idx;
			hit_res.second_index = cross_q ? slot_s4.idx : base_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (take_hit) begin
				pend_valid_q <= 1'b1;
			end else if (take_fin) begin
				pend_valid_q <= 1'b0;
			end
			if ((take_hit || take_fin) && pend_valid_q) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_hit) begin
			pend_q <= hit_res;
		end
		if ((take_hit || take_fin) && pend_valid_q) begin
			out_q <= '{first_index: pend_q.first_index, second_index: pend_q.second_index,
				pair_valid: pend_q.pair_valid, overflow: pend_q.overflow,
				last_of_run: take_fin};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`ASSERT_NEVER(a_count_bound, clk, arst_n, stored_count_q > CW'(MAX_PRIMITIVES))
	`ASSERT_PROP(a_idle_no_pend, clk, arst_n, (state_q == ST_IDLE) |-> !pend_valid_q)
	`ASSERT_PROP(a_fin_to_idle, clk, arst_n, take_fin |=> (state_q == ST_IDLE))
	`ASSERT_NEVER(a_ovf_no_pair, clk, arst_n, out_valid_q && out_q.overflow && (out_q.pair_valid || !out_q.last_of_run))

endmodule
`default_nettype wire

// ----- hw/rtl/bspf_ram.sv -----
`default_nettype none
module bspf_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 32,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Hold the read data while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/bspf_near.sv -----
`default_nettype none
module bspf_near (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  bspf_pkg::slot_t               slot_s1,
	input  bspf_pkg::prim_t               entry_s1,
	input  bspf_pkg::prim_t               item,
	input  logic [bspf_pkg::EXT_BITS-1:0] near_radius,
	output bspf_pkg::slot_t               slot_s4,
	output logic                          hit_s4
);
	import bspf_pkg::*;

	function automatic logic [DIFF_BITS-1:0] abs_diff(
		input logic [COORD_BITS-1:0] a,
		input logic [COORD_BITS-1:0] b
	);
		logic [DIFF_BITS-1:0] d_ab;
		logic [DIFF_BITS-1:0] d_ba;
		d_ab = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
		d_ba = {b[COORD_BITS-1], b} - {a[COORD_BITS-1], a};
		return d_ab[DIFF_BITS-1] ? d_ba : d_ab;
	endfunction

	slot_t                slot_s2, slot_s3;
	logic [DIFF_BITS-1:0] adx_s2, ady_s2, adz_s2;
	logic [SUM_BITS-1:0]  sum_s2;
	logic [SQ_BITS-1:0]   sqx_s3, sqy_s3, sqz_s3, sqs_s3;
	logic                 far_s3;
	logic [ACC_BITS-1:0]  dist_sq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_s2 <= '0;
			slot_s3 <= '0;
			slot_s4 <= '0;
		end else if (advance) begin
			slot_s2 <= slot_s1;
			slot_s3 <= slot_s2;
			slot_s4 <= slot_s3;
		end
	end

	assign dist_sq = ACC_BITS'(sqx_s3) + ACC_BITS'(sqy_s3) + ACC_BITS'(sqz_s3);

	always_ff @(posedge clk) begin
		if (advance) begin
			adx_s2 <= abs_diff(item.x, entry_s1.x);
			ady_s2 <= abs_diff(item.y, entry_s1.y);
			adz_s2 <= abs_diff(item.z, entry_s1.z);
			sum_s2 <= SUM_BITS'(near_radius) + SUM_BITS'(item.extent)
				+ SUM_BITS'(entry_s1.extent);

			sqx_s3 <= SQ_BITS'(adx_s2) * SQ_BITS'(adx_s2);
			sqy_s3 <= SQ_BITS'(ady_s2) * SQ_BITS'(ady_s2);
			sqz_s3 <= SQ_BITS'(adz_s2) * SQ_BITS'(adz_s2);
			sqs_s3 <= SQ_BITS'(sum_s2) * SQ_BITS'(sum_s2);
			// Reject early on an axis gap at or beyond the reach.
			far_s3 <= (sum_s2 == '0)
				|| (MAG_BITS'(adx_s2) >= MAG_BITS'(sum_s2))
				|| (MAG_BITS'(ady_s2) >= MAG_BITS'(sum_s2))
				|| (MAG_BITS'(adz_s2) >= MAG_BITS'(sum_s2));

			hit_s4 <= !far_s3 && (dist_sq < ACC_BITS'(sqs_s3));
		end
	end

endmodule
`default_nettype wire

// ----- verif/tb_bounding_sphere_pair_finder_core.sv -----
`timescale 1ns / 1ps
module tb_bounding_sphere_pair_finder_core;
	import bspf_pkg::*;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam logic [1:0] MODE_NEAR   = 2'd1;
	localparam logic [1:0] MODE_SPARE  = 2'd3;
	localparam int COORD_MAX      = 8388607;
	localparam int COORD_MIN      = -8388608;
	localparam int EXT_FULL       = 8388607;
	localparam int SETTLE_CYCLES  = MAX_PRIMITIVES + 10;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 5000;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	in_item_t                in_data = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	result_t                 out_data;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [EXT_BITS-1:0]     cfg_data = '0;

	bounding_sphere_pair_finder_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predictor state
	logic signed [COORD_BITS-1:0] held_x [MAX_PRIMITIVES];
	logic signed [COORD_BITS-1:0] held_y [MAX_PRIMITIVES];
	logic signed [COORD_BITS-1:0] held_z [MAX_PRIMITIVES];
	logic [EXT_BITS-1:0]          held_ext [MAX_PRIMITIVES];
	int                           held_count = 0;
	logic [IDX_BITS-1:0]          a_seen = '0;
	logic [1:0]                   cur_mode = MODE_NEAR;
	logic [EXT_BITS-1:0]          cur_radius = '0;

	in_item_t items_to_send [$];
	result_t  pair_reports_due [$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int items_accepted = 0;
	int reports_checked = 0;
	int pairs_predicted = 0;
	int overflows_predicted = 0;
	int mismatches = 0;
	int quiet_cycles = 0;
	int hold_left = 0;
	logic hold_used = 1'b0;
	logic hold_go = 1'b0;

	function automatic void add_item(in_item_t it);
		items_to_send.insert(items_to_send.size(), it);
	endfunction

	function automatic longint gap(longint a, longint b);
		return (a >= b) ? a - b : b - a;
	endfunction

	function automatic bit spheres_near(in_item_t it, int k);
		longint s, dx, dy, dz;
		s = longint'(cur_radius) + longint'(it.extent) + longint'(held_ext[k]);
		dx = gap(longint'(it.center_x), longint'(held_x[k]));
		dy = gap(longint'(it.center_y), longint'(held_y[k]));
		dz = gap(longint'(it.center_z), longint'(held_z[k]));
		if (s == 0 || dx >= s || dy >= s || dz >= s)
			return 1'b0;
		return (dx * dx + dy * dy + dz * dz) < s * s;
	endfunction

	function automatic void predict_pair_reports(in_item_t it);
		result_t batch [$];
		result_t r;
		int k;
		if (it.func == FUNC_CLEAR) begin
			held_count = 0;
			a_seen = '0;
			return;
		end
		if (it.func == FUNC_UNUSED)
			return;
		r = '0;
		if (cur_mode == MODE_CROSS && it.func == FUNC_SET_A) begin
			if (a_seen == '1) begin
				r.overflow = 1'b1;
				batch.insert(batch.size(), r);
			end else begin
				for (k = 0; k < held_count; k++) begin
					if (spheres_near(it, k)) begin
						r.first_index = a_seen;
						r.second_index = IDX_BITS'(k);
						r.pair_valid = 1'b1;
						batch.insert(batch.size(), r);
					end
				end
				a_seen++;
			end
		end else if (held_count == MAX_PRIMITIVES) begin
			r.overflow = 1'b1;
			batch.insert(batch.size(), r);
		end else begin
			if (cur_mode != MODE_CROSS) begin
				for (k = 0; k < held_count; k++) begin
					if (cur_mode == MODE_ALL || spheres_near(it, k)) begin
						r.first_index = IDX_BITS'(k);
						r.second_index = IDX_BITS'(held_count);
						r.pair_valid = 1'b1;
						batch.insert(batch.size(), r);
					end
				end
			end
			held_x[held_count] = it.center_x;
			held_y[held_count] = it.center_y;
			held_z[held_count] = it.center_z;
			held_ext[held_count] = it.extent;
			held_count++;
		end
		if (batch.size() != 0)
			batch[batch.size() - 1].last_of_run = 1'b1;
		foreach (batch[j]) begin
			pair_reports_due.insert(pair_reports_due.size(), batch[j]);
			if (batch[j].overflow)
				overflows_predicted++;
			else
				pairs_predicted++;
		end
	endfunction

	function automatic in_item_t make_item(logic [1:0] f, int x, int y, int z, int e);
		in_item_t it;
		it.func = f;
		it.center_x = x[COORD_BITS-1:0];
		it.center_y = y[COORD_BITS-1:0];
		it.center_z = z[COORD_BITS-1:0];
		it.extent = e[EXT_BITS-1:0];
		return it;
	endfunction

	// mostly clear-then-cluster runs, some loose items of any code
	task automatic queue_random_traffic(int n_items);
		int queued, len, nb, spread, cx, cy, cz, i;
		logic [1:0] f;
		in_item_t it;
		queued = 0;
		while (queued < n_items) begin
			if ($urandom_range(99) < 12) begin
				it = make_item(2'($urandom_range(3)), int'($urandom), int'($urandom),
					int'($urandom), int'($urandom));
				add_item(it);
				if (it.func != FUNC_UNUSED)
					queued++;
			end else begin
				add_item(make_item(FUNC_CLEAR, 0, 0, 0, 0));
				queued++;
				len = ($urandom_range(9) == 0) ? int'($urandom_range(30, 36))
					: int'($urandom_range(2, 12));
				nb = int'($urandom_range(1, len - 1));
				spread = 1 << $urandom_range(6, 18);
				cx = int'($urandom_range(1 << 23)) - (1 << 22);
				cy = int'($urandom_range(1 << 23)) - (1 << 22);
				cz = int'($urandom_range(1 << 23)) - (1 << 22);
				for (i = 0; i < len; i++) begin
					if (cur_mode == MODE_CROSS)
						f = (i < nb) ? FUNC_SET_B : FUNC_SET_A;
					else
						f = $urandom_range(1) ? FUNC_SET_B : FUNC_SET_A;
					add_item(make_item(f,
						cx + int'($urandom_range(2 * spread)) - spread,
						cy + int'($urandom_range(2 * spread)) - spread,
						cz + int'($urandom_range(2 * spread)) - spread,
						int'($urandom_range(spread))));
					queued++;
				end
			end
		end
	endtask

	// sampled after the edge so that this step's updates have landed
	task automatic wait_drained();
		do begin
			@(posedge clk);
			#1;
		end while (items_to_send.size() != 0 || in_valid || pair_reports_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(logic [1:0] mode, logic [EXT_BITS-1:0] radius);
		cfg_valid <= 1'b1;
		cfg_index <= REG_PAIR_MODE;
		cfg_data <= EXT_BITS'(mode);
		do @(posedge clk); while (!cfg_ready);
		cur_mode = mode;
		cfg_index <= REG_NEAR_RADIUS;
		cfg_data <= radius;
		do @(posedge clk); while (!cfg_ready);
		cur_radius = radius;
		cfg_valid <= 1'b0;
	endtask

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && in_ready) begin
				predict_pair_reports(in_data);
				items_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_data <= items_to_send.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, armed once
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_used <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_go && !hold_used) begin
			hold_left <= HOLD_CYCLES;
			hold_used <= 1'b1;
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (pair_reports_due.size() == 0) begin
					$error("unexpected result: first_index %0d second_index %0d pair_valid %0b",
						out_data.first_index, out_data.second_index, out_data.pair_valid);
					mismatches++;
				end else begin
					want = pair_reports_due.pop_front();
					reports_checked++;
					if (out_data.first_index !== want.first_index) begin
						$error("first_index: expected %0d, got %0d",
							want.first_index, out_data.first_index);
						mismatches++;
					end
					if (out_data.second_index !== want.second_index) begin
						$error("second_index: expected %0d, got %0d",
							want.second_index, out_data.second_index);
						mismatches++;
					end
					if (out_data.pair_valid !== want.pair_valid) begin
						$error("pair_valid: expected %0b, got %0b",
							want.pair_valid, out_data.pair_valid);
						mismatches++;
					end
					if (out_data.overflow !== want.overflow) begin
						$error("overflow: expected %0b, got %0b",
							want.overflow, out_data.overflow);
						mismatches++;
					end
					if (out_data.last_of_run !== want.last_of_run) begin
						$error("last_of_run: expected %0b, got %0b",
							want.last_of_run, out_data.last_of_run);
						mismatches++;
					end
				end
			end
			out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("tb_bounding_sphere_pair_finder_core: errors");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		int i;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: near pairs among all stored items, zero radius
		add_item(make_item(FUNC_SET_A, 0, 0, 0, 0));
		add_item(make_item(FUNC_SET_B, 0, 0, 0, 0));
		add_item(make_item(FUNC_SET_A, 0, 0, 0, 1));
		add_item(make_item(FUNC_SET_B, COORD_MAX, COORD_MAX, COORD_MAX, EXT_FULL));
		add_item(make_item(FUNC_SET_A, COORD_MIN, COORD_MIN, COORD_MIN, EXT_FULL));
		add_item(make_item(FUNC_UNUSED, COORD_MAX, COORD_MIN, COORD_MAX, EXT_FULL));
		add_item(make_item(FUNC_CLEAR, 0, 0, 0, 0));
		wait_drained();

		set_config(MODE_ALL, EXT_BITS'(EXT_FULL));
		add_item(make_item(FUNC_SET_A, COORD_MIN, COORD_MAX, 0, 0));
		add_item(make_item(FUNC_SET_B, COORD_MAX, COORD_MIN, -1, EXT_FULL));
		add_item(make_item(FUNC_SET_A, -1, -1, -1, 0));
		wait_drained();

		// cross mode: the corner-to-corner case lands exactly on the bound
		set_config(MODE_CROSS, EXT_BITS'(EXT_FULL));
		add_item(make_item(FUNC_CLEAR, 0, 0, 0, 0));
		add_item(make_item(FUNC_SET_B, COORD_MAX, COORD_MAX, COORD_MAX, 0));
		add_item(make_item(FUNC_SET_B, COORD_MIN, COORD_MIN, COORD_MIN, 0));
		add_item(make_item(FUNC_SET_A, 0, 0, 0, EXT_FULL));
		add_item(make_item(FUNC_SET_A, COORD_MIN, COORD_MIN, COORD_MIN, EXT_FULL));
		add_item(make_item(FUNC_UNUSED, 0, 0, 0, 0));
		add_item(make_item(FUNC_SET_A, COORD_MAX, 0, 0, 0));
		wait_drained();

		// spare mode code acts as near mode; distance equal to the sum is not near
		set_config(MODE_SPARE, EXT_BITS'(5));
		add_item(make_item(FUNC_CLEAR, 0, 0, 0, 0));
		add_item(make_item(FUNC_SET_A, 0, 0, 0, 0));
		add_item(make_item(FUNC_SET_B, 3, 4, 0, 0));
		add_item(make_item(FUNC_SET_A, -3, -4, 0, 1));
		wait_drained();

		set_config(MODE_NEAR, EXT_BITS'($urandom_range(1 << 12, 1 << 18)));
		queue_random_traffic(90);
		wait_drained();

		send_idle_pct = 79;
		set_config(MODE_ALL, EXT_BITS'($urandom_range(1 << 16)));
		queue_random_traffic(80);
		wait_drained();

		send_idle_pct = 0;
		recv_stall_pct = 79;
		set_config(MODE_CROSS, EXT_BITS'($urandom_range(1 << 18)));
		queue_random_traffic(90);
		wait_drained();

		send_idle_pct = 16;
		recv_stall_pct = 16;
		set_config(MODE_SPARE, EXT_BITS'($urandom_range(1 << 17)));
		queue_random_traffic(45);
		wait_drained();
		queue_random_traffic(45);
		wait_drained();

		// receiver holds off while the store fills past its limit
		send_idle_pct = 0;
		recv_stall_pct = 0;
		set_config(MODE_ALL, EXT_BITS'(EXT_FULL));
		hold_go <= 1'b1;
		add_item(make_item(FUNC_CLEAR, 0, 0, 0, 0));
		for (i = 0; i < MAX_PRIMITIVES + 2; i++)
			add_item(make_item(2'($urandom_range(1)), int'($urandom), int'($urandom),
				int'($urandom), int'($urandom)));
		wait_drained();

		$display("run summary: %0d items accepted, %0d results checked (%0d pairs, %0d overflow)",
			items_accepted, reports_checked, pairs_predicted, overflows_predicted);
		$display("run covered all four mode codes, radius zero to full scale, store"
			, " saturation, and idle, stall and hold-off mixes");
		if (mismatches == 0)
			$display("tb_bounding_sphere_pair_finder_core: clean");
		else
			$display("tb_bounding_sphere_pair_finder_core: errors");
		$finish;
	end

endmodule
